@@ rtl/core/mdhb_pkg.sv @@
package mdhb_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KindW = 6;

  localparam logic [5:0] K_BUBBLE  = 6'd0;
  localparam logic [5:0] K_ADD     = 6'd1;
  localparam logic [5:0] K_ADDU    = 6'd2;
  localparam logic [5:0] K_SUB     = 6'd3;
  localparam logic [5:0] K_AND     = 6'd4;
  localparam logic [5:0] K_OR      = 6'd5;
  localparam logic [5:0] K_XOR     = 6'd6;
  localparam logic [5:0] K_NOR     = 6'd7;
  localparam logic [5:0] K_NAND    = 6'd8;
  localparam logic [5:0] K_SLT     = 6'd9;
  localparam logic [5:0] K_NOP     = 6'd10;
  localparam logic [5:0] K_SLL     = 6'd11;
  localparam logic [5:0] K_SRL     = 6'd12;
  localparam logic [5:0] K_SRA     = 6'd13;
  localparam logic [5:0] K_JR      = 6'd14;
  localparam logic [5:0] K_MULT    = 6'd15;
  localparam logic [5:0] K_MULTU   = 6'd16;
  localparam logic [5:0] K_MFHI    = 6'd17;
  localparam logic [5:0] K_MFLO    = 6'd18;
  localparam logic [5:0] K_ADDI    = 6'd19;
  localparam logic [5:0] K_ADDIU   = 6'd20;
  localparam logic [5:0] K_LW      = 6'd21;
  localparam logic [5:0] K_LH      = 6'd22;
  localparam logic [5:0] K_LHU     = 6'd23;
  localparam logic [5:0] K_LB      = 6'd24;
  localparam logic [5:0] K_LBU     = 6'd25;
  localparam logic [5:0] K_SW      = 6'd26;
  localparam logic [5:0] K_SH      = 6'd27;
  localparam logic [5:0] K_SB      = 6'd28;
  localparam logic [5:0] K_LUI     = 6'd29;
  localparam logic [5:0] K_ANDI    = 6'd30;
  localparam logic [5:0] K_ORI     = 6'd31;
  localparam logic [5:0] K_NORI    = 6'd32;
  localparam logic [5:0] K_SLTI    = 6'd33;
  localparam logic [5:0] K_BEQ     = 6'd34;
  localparam logic [5:0] K_BNE     = 6'd35;
  localparam logic [5:0] K_BGTZ    = 6'd36;
  localparam logic [5:0] K_J       = 6'd37;
  localparam logic [5:0] K_JAL     = 6'd38;
  localparam logic [5:0] K_HALT    = 6'd39;
  localparam logic [5:0] K_ILLEGAL = 6'd40;

  localparam logic [5:0] OPC_RTYPE = 6'h00;
  localparam logic [5:0] OPC_J     = 6'h02;
  localparam logic [5:0] OPC_JAL   = 6'h03;
  localparam logic [5:0] OPC_BEQ   = 6'h04;
  localparam logic [5:0] OPC_BNE   = 6'h05;
  localparam logic [5:0] OPC_BGTZ  = 6'h07;
  localparam logic [5:0] OPC_ADDI  = 6'h08;
  localparam logic [5:0] OPC_ADDIU = 6'h09;
  localparam logic [5:0] OPC_SLTI  = 6'h0a;
  localparam logic [5:0] OPC_ANDI  = 6'h0c;
  localparam logic [5:0] OPC_ORI   = 6'h0d;
  localparam logic [5:0] OPC_NORI  = 6'h0e;
  localparam logic [5:0] OPC_LUI   = 6'h0f;
  localparam logic [5:0] OPC_LB    = 6'h20;
  localparam logic [5:0] OPC_LH    = 6'h21;
  localparam logic [5:0] OPC_LW    = 6'h23;
  localparam logic [5:0] OPC_LBU   = 6'h24;
  localparam logic [5:0] OPC_LHU   = 6'h25;
  localparam logic [5:0] OPC_SB    = 6'h28;
  localparam logic [5:0] OPC_SH    = 6'h29;
  localparam logic [5:0] OPC_SW    = 6'h2b;
  localparam logic [5:0] OPC_HALT  = 6'h3f;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_NAND  = 6'h28;
  localparam logic [5:0] FN_SLT   = 6'h2a;

  localparam logic [1:0] PROD_NONE = 2'd0;
  localparam logic [1:0] PROD_EX   = 2'd1;
  localparam logic [1:0] PROD_MEM  = 2'd2;
  localparam logic [1:0] PROD_WB   = 2'd3;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] pc_value;
    logic [31:0] rs_file_value;
    logic [31:0] rt_file_value;
    logic [1:0]  rs_producer;
    logic [1:0]  rt_producer;
    logic        ex_ready;
    logic        mem_ready;
    logic [31:0] mem_result;
  } in_item_t;

  typedef struct packed {
    logic        stall_res;
    logic        redirect;
    logic [31:0] next_pc;
    logic [5:0]  op_kind;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] imm_value;
    logic        fwd_a;
    logic        fwd_b;
    logic [31:0] link_value;
    logic        illegal;
  } out_item_t;

endpackage

@@ rtl/core/mdhb_in_if.sv @@
interface mdhb_in_if
  import mdhb_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/mdhb_out_if.sv @@
interface mdhb_out_if
  import mdhb_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/mips_decode_hazard_branch_unit.sv @@
// Channel   Direction  Handshake      Payload
// dec_in    sink       valid, ready   instruction, pc, register values, producer codes
// dec_out   source     valid, ready   stall, redirect, next pc, decoded fields
//
// One instruction is accepted per cycle unless the output stalls.
// Stage one registers the input; decode, hazard check and branch resolution sit
// between that register and the result register.
// Reset clears both valid flags and the pending flush flag.
// A stalled output holds its result; the input register still refills as soon as it drains.
module mips_decode_hazard_branch_unit
  import mdhb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  mdhb_in_if.sink    dec_in,
  mdhb_out_if.source dec_out
);

  in_item_t  s1;
  logic      s1_valid;
  out_item_t res_q;
  logic      res_valid;
  logic      flush_pending;
  logic      flush_pending_next;
  logic      s1_move;
  out_item_t res_next;

  logic [5:0]  opc;
  logic [5:0]  funct;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] se;
  logic [31:0] ze;
  logic [5:0]  kind;
  logic [31:0] imm;
  logic        na;
  logic        nb;
  logic        ctl;
  logic        use_a;
  logic        use_b;
  logic        stall_a;
  logic        stall_b;
  logic        stall;
  logic [31:0] a_val;
  logic [31:0] b_val;
  logic [31:0] pc_inc;
  logic [31:0] btgt;
  logic [31:0] jtgt;

  assign s1_move      = s1_valid && (!res_valid || dec_out.ready);
  assign dec_in.ready = !s1_valid || s1_move;
  assign dec_out.valid = res_valid;
  assign dec_out.data  = res_q;

  assign opc   = s1.instr_word[31:26];
  assign funct = s1.instr_word[5:0];
  assign rs    = s1.instr_word[25:21];
  assign rt    = s1.instr_word[20:16];
  assign rd    = s1.instr_word[15:11];
  assign sh    = s1.instr_word[10:6];
  assign se    = {{16{s1.instr_word[15]}}, s1.instr_word[15:0]};
  assign ze    = {16'd0, s1.instr_word[15:0]};

  always_comb begin
    kind = K_ILLEGAL;
    imm  = '0;
    na   = 1'b0;
    nb   = 1'b0;
    if (opc == OPC_RTYPE) begin
      imm = {27'd0, sh};
      case (funct)
        FN_ADD:   begin kind = K_ADD;   na = 1'b1; nb = 1'b1; end
        FN_ADDU:  begin kind = K_ADDU;  na = 1'b1; nb = 1'b1; end
        FN_SUB:   begin kind = K_SUB;   na = 1'b1; nb = 1'b1; end
        FN_AND:   begin kind = K_AND;   na = 1'b1; nb = 1'b1; end
        FN_OR:    begin kind = K_OR;    na = 1'b1; nb = 1'b1; end
        FN_XOR:   begin kind = K_XOR;   na = 1'b1; nb = 1'b1; end
        FN_NOR:   begin kind = K_NOR;   na = 1'b1; nb = 1'b1; end
        FN_NAND:  begin kind = K_NAND;  na = 1'b1; nb = 1'b1; end
        FN_SLT:   begin kind = K_SLT;   na = 1'b1; nb = 1'b1; end
        FN_SLL: begin
          if (rd == 5'd0 && rt == 5'd0 && sh == 5'd0) begin
            kind = K_NOP;
          end else begin
            kind = K_SLL;
            nb   = 1'b1;
          end
        end
        FN_SRL:   begin kind = K_SRL;   nb = 1'b1; end
        FN_SRA:   begin kind = K_SRA;   nb = 1'b1; end
        FN_JR:    begin kind = K_JR;    na = 1'b1; end
        FN_MULT:  begin kind = K_MULT;  na = 1'b1; nb = 1'b1; end
        FN_MULTU: begin kind = K_MULTU; na = 1'b1; nb = 1'b1; end
        FN_MFHI:  kind = K_MFHI;
        FN_MFLO:  kind = K_MFLO;
        default:  kind = K_ILLEGAL;
      endcase
    end else begin
      case (opc)
        OPC_ADDI:  begin kind = K_ADDI;  imm = se; na = 1'b1; end
        OPC_ADDIU: begin kind = K_ADDIU; imm = se; na = 1'b1; end
        OPC_LW:    begin kind = K_LW;    imm = se; na = 1'b1; end
        OPC_LH:    begin kind = K_LH;    imm = se; na = 1'b1; end
        OPC_LHU:   begin kind = K_LHU;   imm = se; na = 1'b1; end
        OPC_LB:    begin kind = K_LB;    imm = se; na = 1'b1; end
        OPC_LBU:   begin kind = K_LBU;   imm = se; na = 1'b1; end
        OPC_SW:    begin kind = K_SW;    imm = se; na = 1'b1; nb = 1'b1; end
        OPC_SH:    begin kind = K_SH;    imm = se; na = 1'b1; nb = 1'b1; end
        OPC_SB:    begin kind = K_SB;    imm = se; na = 1'b1; nb = 1'b1; end
        OPC_LUI:   begin kind = K_LUI;   imm = ze; end
        OPC_ANDI:  begin kind = K_ANDI;  imm = ze; na = 1'b1; end
        OPC_ORI:   begin kind = K_ORI;   imm = ze; na = 1'b1; end
        OPC_NORI:  begin kind = K_NORI;  imm = ze; na = 1'b1; end
        OPC_SLTI:  begin kind = K_SLTI;  imm = se; na = 1'b1; end
        OPC_BEQ:   begin kind = K_BEQ;   imm = se; na = 1'b1; nb = 1'b1; end
        OPC_BNE:   begin kind = K_BNE;   imm = se; na = 1'b1; nb = 1'b1; end
        OPC_BGTZ:  begin kind = K_BGTZ;  imm = se; na = 1'b1; end
        OPC_J:     begin kind = K_J;   imm = {6'd0, s1.instr_word[25:0]}; end
        OPC_JAL:   begin kind = K_JAL; imm = {6'd0, s1.instr_word[25:0]}; end
        OPC_HALT:  kind = K_HALT;
        default:   kind = K_ILLEGAL;
      endcase
    end
  end

  // Control instructions take the register file value, forward the memory-stage
  // result, or stall; all others stall only behind an execute result not yet ready.
  assign ctl   = (kind == K_JR) || (kind == K_BEQ) || (kind == K_BNE) || (kind == K_BGTZ);
  assign use_a = na && (rs != 5'd0);
  assign use_b = nb && (rt != 5'd0);

  always_comb begin
    if (ctl) begin
      stall_a = use_a && (s1.rs_producer == PROD_EX ||
                          (s1.rs_producer == PROD_MEM && !s1.mem_ready));
      stall_b = use_b && (s1.rt_producer == PROD_EX ||
                          (s1.rt_producer == PROD_MEM && !s1.mem_ready));
    end else begin
      stall_a = use_a && s1.rs_producer == PROD_EX && !s1.ex_ready;
      stall_b = use_b && s1.rt_producer == PROD_EX && !s1.ex_ready;
    end
  end

  assign stall = stall_a || stall_b;
  assign a_val = !(ctl && use_a)           ? '0 :
                 (s1.rs_producer == PROD_MEM) ? s1.mem_result : s1.rs_file_value;
  assign b_val = !(ctl && use_b)           ? '0 :
                 (s1.rt_producer == PROD_MEM) ? s1.mem_result : s1.rt_file_value;

  assign pc_inc = s1.pc_value + 32'd4;
  assign btgt   = s1.pc_value + {imm[29:0], 2'b00};
  assign jtgt   = {s1.pc_value[31:28], imm[25:0], 2'b00};

  always_comb begin
    res_next           = '0;
    res_next.next_pc   = pc_inc;
    flush_pending_next = 1'b0;
    if (!flush_pending) begin
      res_next.op_kind = kind;
      if (kind == K_ILLEGAL) begin
        res_next.illegal = 1'b1;
      end else if (stall) begin
        res_next.stall_res = 1'b1;
        res_next.imm_value = imm;
      end else begin
        res_next.imm_value = imm;
        res_next.operand_a = a_val;
        res_next.operand_b = b_val;
        res_next.fwd_a     = ctl && use_a && (s1.rs_producer == PROD_MEM);
        res_next.fwd_b     = ctl && use_b && (s1.rt_producer == PROD_MEM);
        case (kind)
          K_JR: begin
            res_next.next_pc  = a_val;
            res_next.redirect = 1'b1;
          end
          K_BEQ: begin
            if (a_val == b_val) begin
              res_next.next_pc  = btgt;
              res_next.redirect = 1'b1;
            end
          end
          K_BNE: begin
            if (a_val != b_val) begin
              res_next.next_pc  = btgt;
              res_next.redirect = 1'b1;
            end
          end
          K_BGTZ: begin
            if (!a_val[31] && a_val != '0) begin
              res_next.next_pc  = btgt;
              res_next.redirect = 1'b1;
            end
          end
          K_J: begin
            res_next.next_pc  = jtgt;
            res_next.redirect = 1'b1;
          end
          K_JAL: begin
            res_next.next_pc    = jtgt;
            res_next.link_value = s1.pc_value;
            res_next.redirect   = 1'b1;
          end
          default: res_next.redirect = 1'b0;
        endcase
        flush_pending_next = res_next.redirect;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      res_valid     <= 1'b0;
      flush_pending <= 1'b0;
    end else begin
      if (dec_in.ready) begin
        s1_valid <= dec_in.valid;
      end
      if (s1_move) begin
        res_valid     <= 1'b1;
        flush_pending <= flush_pending_next;
      end else if (dec_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec_in.valid && dec_in.ready) begin
      s1 <= dec_in.data;
    end
    if (s1_move) begin
      res_q <= res_next;
    end
  end

endmodule

@@ rtl/core/mdhb_checker.sv @@
module mdhb_checker
  import mdhb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data
);

  logic after_redirect;

  // Tracks whether the last result transferred was a taken redirect.
  always_ff @(posedge clk) begin
    if (rst) begin
      after_redirect <= 1'b0;
    end else if (out_valid && out_ready) begin
      after_redirect <= out_data.redirect;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed before its transfer.");

  a_bubble_after_redirect: assert property (@(posedge clk) disable iff (rst)
    out_valid && after_redirect |-> out_data.op_kind == K_BUBBLE)
    else $error("Result after a redirect is not a bubble.");

  a_stall_no_redirect: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.stall_res |->
      !out_data.redirect && out_data.operand_a == '0 && out_data.link_value == '0)
    else $error("Stalled result carries a redirect or operands.");

  a_illegal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.illegal |->
      out_data.op_kind == K_ILLEGAL && !out_data.stall_res && !out_data.redirect)
    else $error("Illegal result is inconsistent.");

  a_bubble_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.op_kind == K_BUBBLE |->
      !out_data.stall_res && !out_data.redirect && out_data.imm_value == '0)
    else $error("Bubble carries a stall, redirect or immediate.");

endmodule

bind mips_decode_hazard_branch_unit mdhb_checker u_mdhb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (dec_out.valid),
  .out_ready (dec_out.ready),
  .out_data  (dec_out.data)
);
